// File: src/psbm_pkg.sv
// Package for the pinyin syllable boundary marker: transaction types,
// letter width and the fixed letter classes. No dependencies.
`default_nettype none

package psbm_pkg;

  // Letters are taken modulo 2^CHAR_BITS; the ports carry 8 bits.
  localparam int CHAR_BITS   = 8;
  localparam int LETTER_BITS = (CHAR_BITS < 8) ? CHAR_BITS : 8;

  // Result queue: a word's last letter can release three results at once.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_PUSH    = 3;

  typedef logic [LETTER_BITS-1:0] letter_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_of_word;
  } in_t;

  typedef struct packed {
    logic [7:0] letter_out;
    logic       starts_syllable;
    logic       end_of_word;
  } out_t;

  function automatic logic [7:0] ext8(letter_t c);
    return 8'(c);
  endfunction

  // b c d f j k l m p q s t w x y z
  function automatic logic is_always(letter_t c);
    logic r;
    case (ext8(c)) inside
      "b", "c", "d", "f", "j", "k", "l", "m",
      "p", "q", "s", "t", "w", "x", "y", "z": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_zcs(letter_t c);
    logic r;
    case (ext8(c)) inside
      "z", "c", "s": r = 1'b1;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_a_after(letter_t c);
    logic r;
    case (ext8(c)) inside
      "a", "e", "o": r = 1'b1;
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_e_after(letter_t c);
    logic r;
    case (ext8(c)) inside
      "a", "e", "j", "o", "q", "x": r = 1'b1;
      default:                      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_o_after(letter_t c);
    logic r;
    case (ext8(c)) inside
      "e", "j", "o", "q", "v", "x": r = 1'b1;
      default:                      r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_n_after(letter_t c);
    logic r;
    case (ext8(c)) inside
      "b", "c", "d", "f", "g", "h", "j", "k", "l", "m", "n",
      "p", "q", "r", "s", "t", "v", "w", "x", "y", "z": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_i_back1(letter_t c);
    logic r;
    case (ext8(c)) inside
      "b", "c", "d", "j", "l", "m", "n", "p", "q", "s", "t", "x", "y": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_u_back1(letter_t c);
    logic r;
    case (ext8(c)) inside
      "b", "c", "d", "f", "g", "j", "k", "l",
      "n", "q", "r", "s", "t", "w", "y", "z": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_v_back1(letter_t c);
    logic r;
    case (ext8(c)) inside
      "l", "n": r = 1'b1;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/pinyin_syllable_boundary_marker.sv
// Top level of the pinyin syllable boundary marker: input register, letter
// rules, two-letter window and result queue. Depends on psbm_pkg.
`default_nettype none

// Takes one letter of a pinyin word per transaction on the letter channel and
// reports each letter on the result channel with a flag that is set where a
// new syllable begins. A rule on i, u and v can mark the letter one or two
// places back, so a letter is reported two letters after it arrives; the
// transaction that carries the word's last letter releases the letters still
// held, up to three results, the last with end_of_word set. A word of one or
// two letters gives its results only at its last letter. Every letter
// transaction is registered and processed once the four-entry result queue
// has room for three results, so one letter per cycle is taken while the
// queue has room; a word end can hold the letter channel while the queue
// drains. Stalls on the result side back up into the letter channel through
// that queue. Codes that are not lower-case letters pass through and are
// marked only when they open a word. Reset clears the window and the queue.
module pinyin_syllable_boundary_marker
  import psbm_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic letter_valid,
  output logic       letter_stall,
  input  wire  in_t  letter_data,
  output logic       result_valid,
  input  wire  logic result_stall,
  output out_t       result_data
);

  // input register
  logic    in_full;
  in_t     in_reg;
  logic    process;

  // two-letter window
  letter_t prev_letter_one;
  letter_t prev_letter_two;
  logic    prev_flag_one;
  logic    prev_flag_two;
  logic [1:0] letters_seen;

  // result queue
  out_t                queue [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                pop;

  // rule evaluation
  letter_t c;
  letter_t p;
  logic    last;
  logic    fc;
  logic    back_one;
  logic    back_two;
  logic    flag_one;
  logic    flag_two;

  out_t                push_item  [MAX_PUSH];
  logic                push_valid [MAX_PUSH];
  logic [PTR_BITS-1:0] push_addr  [MAX_PUSH];
  logic [CNT_BITS-1:0] push_count;

  assign process      = in_full && (count <= CNT_BITS'(QUEUE_DEPTH - MAX_PUSH));
  assign letter_stall = in_full && !process;
  assign pop          = result_valid && !result_stall;
  assign result_valid = (count != '0);
  assign result_data  = queue[rd_ptr];

  assign c    = in_reg.char_code[LETTER_BITS-1:0];
  assign last = in_reg.last_of_word;
  assign p    = prev_letter_one;

  always_comb begin
    fc       = 1'b0;
    back_one = 1'b0;
    back_two = 1'b0;
    if (letters_seen == 2'd0) begin
      fc = 1'b1;
    end else begin
      if (is_always(c)) begin
        fc = 1'b1;
      end else if (ext8(c) == "g") begin
        fc = (ext8(p) != "n");
      end else if (ext8(c) == "h") begin
        fc = !is_zcs(p);
      end else if (ext8(c) == "r") begin
        fc = (ext8(p) != "e");
      end else if (ext8(c) == "a") begin
        fc = is_a_after(p);
      end else if (ext8(c) == "e") begin
        fc = is_e_after(p);
      end else if (ext8(c) == "o") begin
        fc = is_o_after(p);
      end else if (ext8(c) == "n") begin
        fc = is_n_after(p);
      end
      // backward rule, only where the letter itself is unmarked
      if (!fc) begin
        if (ext8(c) == "i") begin
          if (is_i_back1(p)) begin
            back_one = 1'b1;
          end else if (ext8(p) == "h" && letters_seen >= 2'd2 &&
                       is_zcs(prev_letter_two)) begin
            back_two = 1'b1;
          end
        end else if (ext8(c) == "u") begin
          back_one = is_u_back1(p);
        end else if (ext8(c) == "v") begin
          back_one = is_v_back1(p);
        end
      end
    end
  end

  assign flag_one = prev_flag_one | back_one;
  assign flag_two = prev_flag_two | back_two;

  // Results in order: letter two back, then on a word end the letter one
  // back and the current letter.
  always_comb begin
    push_item[0]  = '{letter_out: ext8(prev_letter_two), starts_syllable: flag_two,
                      end_of_word: 1'b0};
    push_valid[0] = (letters_seen >= 2'd2);
    push_item[1]  = '{letter_out: ext8(prev_letter_one), starts_syllable: flag_one,
                      end_of_word: 1'b0};
    push_valid[1] = last && (letters_seen != 2'd0);
    push_item[2]  = '{letter_out: ext8(c), starts_syllable: fc, end_of_word: 1'b1};
    push_valid[2] = last;
  end

  always_comb begin
    logic [PTR_BITS-1:0] addr;
    logic [CNT_BITS-1:0] n;
    addr = wr_ptr;
    n    = '0;
    for (int k = 0; k < MAX_PUSH; k++) begin
      push_addr[k] = addr;
      if (push_valid[k]) begin
        addr = addr + PTR_BITS'(1);
        n    = n + CNT_BITS'(1);
      end
    end
    push_count = process ? n : '0;
  end

  // control: input register valid, window, queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full         <= 1'b0;
      prev_letter_one <= '0;
      prev_letter_two <= '0;
      prev_flag_one   <= 1'b0;
      prev_flag_two   <= 1'b0;
      letters_seen    <= 2'd0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      if (!letter_stall) begin
        in_full <= letter_valid;
      end
      if (process) begin
        if (last) begin
          prev_letter_one <= '0;
          prev_letter_two <= '0;
          prev_flag_one   <= 1'b0;
          prev_flag_two   <= 1'b0;
          letters_seen    <= 2'd0;
        end else begin
          prev_letter_two <= prev_letter_one;
          prev_flag_two   <= flag_one;
          prev_letter_one <= c;
          prev_flag_one   <= fc;
          if (letters_seen < 2'd2) begin
            letters_seen <= letters_seen + 2'd1;
          end
        end
      end
      wr_ptr <= wr_ptr + PTR_BITS'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + push_count - CNT_BITS'(pop);
    end
  end

  // payload: input register and queue entries
  always_ff @(posedge clk) begin
    if (!letter_stall) begin
      in_reg <= letter_data;
    end
    if (process) begin
      for (int k = 0; k < MAX_PUSH; k++) begin
        if (push_valid[k]) begin
          queue[push_addr[k]] <= push_item[k];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/psbm_checker.sv
// Port-level checker for the pinyin syllable boundary marker, with its bind.
// Depends on psbm_pkg and the top level.
`default_nettype none

module psbm_checker
  import psbm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic letter_valid,
  input wire logic letter_stall,
  input wire in_t  letter_data,
  input wire logic result_valid,
  input wire logic result_stall,
  input wire out_t result_data
);

  // a stalled letter transaction holds
  a_letter_hold: assert property (@(posedge clk) disable iff (rst)
    letter_valid && letter_stall |=> letter_valid && $stable(letter_data))
    else $error("letter transaction changed while stalled");

  // a stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("result transaction changed while stalled");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // reset empties the input register
  a_reset_ready: assert property (@(posedge clk)
    rst |=> !letter_stall)
    else $error("letter channel stalled right after reset");

  // a new stall needs a letter taken in the cycle before
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(letter_stall) |-> $past(letter_valid))
    else $error("letter stall with no letter held");

endmodule

bind pinyin_syllable_boundary_marker psbm_checker u_psbm_checker (
  .clk          (clk),
  .rst          (rst),
  .letter_valid (letter_valid),
  .letter_stall (letter_stall),
  .letter_data  (letter_data),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_data  (result_data)
);

`default_nettype wire

// File: sim/testbench.sv
// Testbench for the pinyin syllable boundary marker: directed and random pinyin
// words, checked one result at a time against a letter-rule predictor.
// Depends on psbm_pkg and the pinyin_syllable_boundary_marker RTL.
`timescale 1ns / 100ps

module testbench;
  import psbm_pkg::*;

  typedef logic [7:0] word_t[$];

  // Idle cycles with no transaction on either channel before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // Long hold-off on the result side, used to fill the block and stall its input.
  localparam int unsigned HOLD_CYCLES    = 64;
  // Quiet cycles after the last result, to catch anything extra.
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned TOTAL_LETTERS  = 450;

  logic clk;
  logic rst;
  logic letter_valid;
  logic letter_stall;
  in_t  letter_data;
  logic result_valid;
  logic result_stall;
  out_t result_data;

  pinyin_syllable_boundary_marker dut (
    .clk          (clk),
    .rst          (rst),
    .letter_valid (letter_valid),
    .letter_stall (letter_stall),
    .letter_data  (letter_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  // Predictor window: the two letters still held and their marks.
  logic [7:0]  win_letter1;
  logic [7:0]  win_letter2;
  logic        win_mark1;
  logic        win_mark2;
  int unsigned win_count;

  // Results predicted but not yet seen on the result channel, oldest first.
  out_t        pending_letters[$];

  int unsigned mismatches   = 0;
  int unsigned letters_sent = 0;
  int unsigned idle_cycles  = 0;

  // Traffic shaping knobs, flipped by the test tasks.
  bit tx_quiet     = 1'b0;  // sender offers back to back
  bit rx_quiet     = 1'b0;  // receiver never stalls
  bit hold_results = 1'b0;  // receiver holds off for HOLD_CYCLES

  // Syllable pieces for well-formed words; an empty initial gives a bare final.
  string initials [24] = '{"b", "p", "m", "f", "d", "t", "n", "l", "g", "k", "h", "j",
                           "q", "x", "zh", "ch", "sh", "r", "z", "c", "s", "y", "w", ""};
  string finals [32] = '{"a", "o", "e", "i", "u", "v", "ai", "ei", "ao", "ou", "an",
                         "en", "ang", "eng", "ong", "er", "ia", "ie", "iao", "iu",
                         "ian", "in", "iang", "ing", "ua", "uo", "uai", "ui", "uan",
                         "un", "uang", "ve"};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length shared by both sides: mostly none or short, now and then long.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)      return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else             return $urandom_range(20, 40);
  endfunction

  // Letter rules over the window. The current letter gets its own mark; the
  // backward rule on i, u and v may set the mark of one or two letters back.
  // A word reports each letter two letters late and flushes at its last letter.
  task automatic predict_marks(input in_t item);
    logic [7:0] c;
    logic [7:0] p;
    logic       mark;
    c    = item.char_code;
    p    = win_letter1;
    mark = 1'b0;
    if (win_count == 0) begin
      mark = 1'b1;
    end else begin
      case (c)
        "b", "c", "d", "f", "j", "k", "l", "m",
        "p", "q", "s", "t", "w", "x", "y", "z": mark = 1'b1;
        "g": mark = (p != "n");
        "h": mark = !(p inside {"z", "c", "s"});
        "r": mark = (p != "e");
        "a": mark = p inside {"a", "e", "o"};
        "e": mark = p inside {"a", "e", "j", "o", "q", "x"};
        "o": mark = p inside {"e", "j", "o", "q", "v", "x"};
        "n": mark = p inside {"b", "c", "d", "f", "g", "h", "j", "k", "l", "m", "n",
                              "p", "q", "r", "s", "t", "v", "w", "x", "y", "z"};
        default: mark = 1'b0;
      endcase
      if (!mark) begin
        case (c)
          "i": begin
            if (p inside {"b", "c", "d", "j", "l", "m", "n", "p", "q", "s", "t", "x", "y"})
              win_mark1 = 1'b1;
            // zhi / chi / shi: only when the sibilant is inside this word
            else if (p == "h" && win_count >= 2 && win_letter2 inside {"c", "s", "z"})
              win_mark2 = 1'b1;
          end
          "u": begin
            if (p inside {"b", "c", "d", "f", "g", "j", "k", "l",
                          "n", "q", "r", "s", "t", "w", "y", "z"})
              win_mark1 = 1'b1;
          end
          "v": begin
            if (p inside {"l", "n"})
              win_mark1 = 1'b1;
          end
          default: ;
        endcase
      end
    end

    if (win_count >= 2)
      pending_letters.push_back('{letter_out: win_letter2, starts_syllable: win_mark2,
                                  end_of_word: 1'b0});

    if (item.last_of_word) begin
      if (win_count >= 1)
        pending_letters.push_back('{letter_out: win_letter1, starts_syllable: win_mark1,
                                    end_of_word: 1'b0});
      pending_letters.push_back('{letter_out: c, starts_syllable: mark, end_of_word: 1'b1});
      win_letter1 = '0;
      win_letter2 = '0;
      win_mark1   = 1'b0;
      win_mark2   = 1'b0;
      win_count   = 0;
    end else begin
      win_letter2 = win_letter1;
      win_mark2   = win_mark1;
      win_letter1 = c;
      win_mark1   = mark;
      if (win_count < 2)
        win_count++;
    end
  endtask

  // One letter transaction. Valid stays high into the next letter when there
  // is no gap, so it is never lowered and raised in the same step.
  task automatic send_letter(input logic [7:0] code, input logic last);
    in_t         item;
    int unsigned gap;
    item.char_code    = code;
    item.last_of_word = last;
    letter_data  <= item;
    letter_valid <= 1'b1;
    @(posedge clk);
    while (letter_stall) @(posedge clk);
    predict_marks(item);
    letters_sent++;
    gap = tx_quiet ? 0 : idle_gap();
    if (gap > 0) begin
      letter_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_word(input word_t w);
    for (int k = 0; k < w.size(); k++)
      send_letter(w[k], k == w.size() - 1);
  endtask

  task automatic send_text(input string s);
    word_t w;
    for (int k = 0; k < s.len(); k++)
      w.push_back(s[k]);
    send_word(w);
  endtask

  // Sender goes quiet until every predicted result has come out.
  task automatic wait_drain();
    letter_valid <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk);
  endtask

  function automatic word_t pinyin_word();
    word_t w;
    string s;
    int unsigned n;
    s = "";
    n = $urandom_range(1, 4);
    repeat (n)
      s = {s, initials[$urandom_range(0, 23)], finals[$urandom_range(0, 31)]};
    for (int k = 0; k < s.len(); k++)
      w.push_back(s[k]);
    return w;
  endfunction

  // Mostly well-formed pinyin, then pinyin words with one letter swapped for an
  // arbitrary byte code, lower-case junk (sometimes long) and words of arbitrary byte codes.
  function automatic word_t random_word();
    word_t w;
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      w = pinyin_word();
    end else if (r < 75) begin
      w = pinyin_word();
      w[$urandom_range(0, w.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 88) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 6);
      repeat (n) w.push_back(8'($urandom_range("a", "z")));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) w.push_back(8'($urandom_range(0, 255)));
    end
    return w;
  endfunction

  // Single letter, codes 0x00 and 0xFF, the three retroflex i cases, an i
  // whose two-back match would fall before the word start, and v, u, e, r, g.
  task automatic test_directed();
    word_t w;
    send_text("a");
    w = '{8'h00, 8'hFF};
    send_word(w);
    send_text("zhi");
    send_text("chi");
    send_text("shi");
    send_text("hi");
    send_text("lv");
    send_text("nuer");
    send_text("ger");
    wait_drain();
  endtask

  // Receiver holds off while the sender keeps offering back to back, so the
  // result queue fills and the letter channel stalls.
  task automatic test_backpressure();
    int unsigned start;
    start        = letters_sent;
    tx_quiet     = 1'b1;
    hold_results = 1'b1;
    while (letters_sent - start < 30)
      send_word(pinyin_word());
    tx_quiet = 1'b0;
    wait_drain();
  endtask

  // Full rate on both sides, no idling at all.
  task automatic test_full_rate();
    int unsigned start;
    start    = letters_sent;
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    while (letters_sent - start < 40)
      send_word(random_word());
    wait_drain();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Random traffic with a full pause halfway through.
  task automatic test_random();
    int unsigned half;
    half = letters_sent + (TOTAL_LETTERS - letters_sent) / 2;
    while (letters_sent < half)
      send_word(random_word());
    wait_drain();
    while (letters_sent < TOTAL_LETTERS)
      send_word(random_word());
    wait_drain();
  endtask

  // Result-side stall generator; the long hold is counted here.
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_results = 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat (idle_gap() + 1) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_letters.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual %h/%b/%b", $time,
                 result_data.letter_out, result_data.starts_syllable,
                 result_data.end_of_word);
      end else begin
        want = pending_letters.pop_front();
        if (result_data.letter_out !== want.letter_out) begin
          mismatches++;
          $display("%0t: letter_out: expected %h, actual %h", $time,
                   want.letter_out, result_data.letter_out);
        end
        if (result_data.starts_syllable !== want.starts_syllable) begin
          mismatches++;
          $display("%0t: starts_syllable (letter %h): expected %b, actual %b", $time,
                   want.letter_out, want.starts_syllable, result_data.starts_syllable);
        end
        if (result_data.end_of_word !== want.end_of_word) begin
          mismatches++;
          $display("%0t: end_of_word (letter %h): expected %b, actual %b", $time,
                   want.letter_out, want.end_of_word, result_data.end_of_word);
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (letter_valid && !letter_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_letters.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    win_letter1 = '0;
    win_letter2 = '0;
    win_mark1   = 1'b0;
    win_mark2   = 1'b0;
    win_count   = 0;
    letter_valid <= 1'b0;
    letter_data  <= '0;
    rst          <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_full_rate();
    test_random();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
